FILE: rtl/core/dcclp_pkg.sv
// Shared types and codes of the data cache directory and replacement engine.
`default_nettype none
package dcclp_pkg;

  // Access kinds; any other code acts as a load
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_STORE  = 2'd1;
  localparam logic [1:0] MODE_MODIFY = 2'd2;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_DEMAND = 5'b00100,
    ST_PREF   = 5'b01000,
    ST_SPARE  = 5'b10000
  } state_t;

  typedef struct packed {
    logic clear;   // write one zero row of the clearing pass
    logic accept;  // latch a new item, read its demand set
    logic look;    // evaluate the demand set, read the next-line set
    logic pref;    // evaluate the next-line set
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic hit;
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/core/data_cache_clock_lip_prefetch.sv
// Top level of the write-back data cache directory with clock replacement and prefetch.
//
//  channel  | handshake                 | fields
//  ---------+---------------------------+-------------------------------------------
//  access   | start, taken when !busy   | mode, address
//  result   | done, one-cycle strobe    | hit, demand_way, evict_*, fill_line, prefetch_*
//
// The done strobe is registered from the demand step on a hit and from the next-line
// step on a miss (demand set read and written back, then next-line set read and written
// back on a miss, one set RAM port pair); the next item waits for these steps.
// The strobe cycle overlaps idle, so a new item can be taken during it.
// After reset a clearing pass writes every set with busy high.
// Results cannot be stalled; each is shown for exactly one cycle.
`default_nettype none
module data_cache_clock_lip_prefetch #(
  parameter int SETS       = 128,
  parameter int WAYS       = 8,
  parameter int LINE_BYTES = 64,
  parameter int ADDR_WIDTH = 48,
  localparam int WAY_W  = $clog2(WAYS),
  localparam int LINE_W = ADDR_WIDTH - $clog2(LINE_BYTES)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            mode,
  input  wire logic [ADDR_WIDTH-1:0] address,
  output logic                       done,
  output logic                       hit,
  output logic [WAY_W-1:0]           demand_way,
  output logic                       evict_dirty,
  output logic [LINE_W-1:0]          evict_line,
  output logic [LINE_W-1:0]          fill_line,
  output logic                       prefetch_fill,
  output logic [LINE_W-1:0]          prefetch_line,
  output logic [WAY_W-1:0]           prefetch_way,
  output logic                       prefetch_evict_dirty,
  output logic [LINE_W-1:0]          prefetch_evict_line
);
  import dcclp_pkg::*;

  cmd_t    cmd;
  status_t sts;

  dcclp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  dcclp_dp #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .LINE_BYTES (LINE_BYTES),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .sts                  (sts),
    .mode                 (mode),
    .address              (address),
    .done                 (done),
    .hit                  (hit),
    .demand_way           (demand_way),
    .evict_dirty          (evict_dirty),
    .evict_line           (evict_line),
    .fill_line            (fill_line),
    .prefetch_fill        (prefetch_fill),
    .prefetch_line        (prefetch_line),
    .prefetch_way         (prefetch_way),
    .prefetch_evict_dirty (prefetch_evict_dirty),
    .prefetch_evict_line  (prefetch_evict_line)
  );
endmodule
`default_nettype wire

FILE: rtl/core/dcclp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dcclp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/core/dcclp_ctrl.sv
// Sequencer of the cache engine: clearing pass, demand and prefetch steps.
`default_nettype none
module dcclp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire dcclp_pkg::status_t sts,
  output dcclp_pkg::cmd_t       cmd
);
  import dcclp_pkg::*;

  state_t state, state_next;

  // Advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Pick the next step
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (sts.clear_done) state_next = ST_IDLE;
      ST_IDLE:   if (start) state_next = ST_DEMAND;
      ST_DEMAND: state_next = sts.hit ? ST_IDLE : ST_PREF;
      ST_PREF:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign busy       = (state != ST_IDLE);
  assign cmd.clear  = (state == ST_CLEAR);
  assign cmd.accept = (state == ST_IDLE) && start;
  assign cmd.look   = (state == ST_DEMAND);
  assign cmd.pref   = (state == ST_PREF);
endmodule
`default_nettype wire

FILE: rtl/core/dcclp_dp.sv
// Datapath of the cache engine: set RAM, lookup, victim choice, result registers.
`default_nettype none
module dcclp_dp #(
  parameter int SETS       = 128,
  parameter int WAYS       = 8,
  parameter int LINE_BYTES = 64,
  parameter int ADDR_WIDTH = 48,
  localparam int WAY_W  = $clog2(WAYS),
  localparam int LINE_W = ADDR_WIDTH - $clog2(LINE_BYTES)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dcclp_pkg::cmd_t       cmd,
  output dcclp_pkg::status_t         sts,
  input  wire logic [1:0]            mode,
  input  wire logic [ADDR_WIDTH-1:0] address,
  output logic                       done,
  output logic                       hit,
  output logic [WAY_W-1:0]           demand_way,
  output logic                       evict_dirty,
  output logic [LINE_W-1:0]          evict_line,
  output logic [LINE_W-1:0]          fill_line,
  output logic                       prefetch_fill,
  output logic [LINE_W-1:0]          prefetch_line,
  output logic [WAY_W-1:0]           prefetch_way,
  output logic                       prefetch_evict_dirty,
  output logic [LINE_W-1:0]          prefetch_evict_line
);
  import dcclp_pkg::*;

  localparam int OFF_W = $clog2(LINE_BYTES);
  localparam int SET_W = $clog2(SETS);
  localparam int TAG_W = LINE_W - SET_W;
  localparam int TB    = WAYS * TAG_W;
  localparam int ROW_W = TB + 3 * WAYS + WAY_W;

  logic              writes_q;
  logic [LINE_W-1:0] line_q;
  logic [LINE_W-1:0] pline;
  logic [SET_W-1:0]  clr_cnt;

  logic              we;
  logic [SET_W-1:0]  waddr, raddr;
  logic [ROW_W-1:0]  wdata, rdata;

  // Row fields
  logic [TAG_W-1:0]  tags [WAYS];
  logic [WAYS-1:0]   valid, dirty, used;
  logic [WAY_W-1:0]  hand;

  // Evaluation
  logic [TAG_W-1:0]  tag_e;
  logic [SET_W-1:0]  set_e;
  logic              dirty_e;
  logic              hit_e, inv_f, free_f;
  logic [WAY_W-1:0]  hit_way, inv_way, vic_way, hand_n;
  logic [WAY_W:0]    sel_k, idx;
  logic [WAYS-1:0]   used_n, dirty_n, valid_n;
  logic              evd_e;
  logic [LINE_W-1:0] evl_e;
  logic [ROW_W-1:0]  row_n;

  assign pline = line_q + LINE_W'(1);

  // Latch the item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      writes_q <= (mode == MODE_STORE) || (mode == MODE_MODIFY);
      line_q   <= address[ADDR_WIDTH-1:OFF_W];
    end
  end

  // Step through all sets after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + SET_W'(1);
    end
  end
  assign sts.clear_done = cmd.clear && (clr_cnt == SET_W'(SETS - 1));

  // Unpack the row that was read
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      tags[w] = rdata[w*TAG_W +: TAG_W];
    end
    valid = rdata[TB +: WAYS];
    dirty = rdata[TB + WAYS +: WAYS];
    used  = rdata[TB + 2*WAYS +: WAYS];
    hand  = rdata[TB + 3*WAYS +: WAY_W];
  end

  assign tag_e   = cmd.pref ? pline[LINE_W-1:SET_W] : line_q[LINE_W-1:SET_W];
  assign set_e   = cmd.pref ? pline[SET_W-1:0] : line_q[SET_W-1:0];
  assign dirty_e = cmd.pref ? 1'b0 : writes_q;

  // Look up the tag and find the lowest invalid way
  always_comb begin
    hit_e   = 1'b0;
    hit_way = '0;
    inv_f   = 1'b0;
    inv_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (valid[w] && (tags[w] == tag_e)) begin
        hit_e   = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!valid[w]) begin
        inv_f   = 1'b1;
        inv_way = WAY_W'(w);
      end
    end
  end

  // Clock sweep: first clear use bit from the hand, clearing those passed
  always_comb begin
    free_f = 1'b0;
    sel_k  = '0;
    idx    = '0;
    used_n = used;
    for (int k = WAYS - 1; k >= 0; k--) begin
      idx = {1'b0, hand} + (WAY_W+1)'(k);
      if (idx >= (WAY_W+1)'(WAYS)) idx = idx - (WAY_W+1)'(WAYS);
      if (!used[idx[WAY_W-1:0]]) begin
        free_f = 1'b1;
        sel_k  = (WAY_W+1)'(k);
      end
    end
    idx = {1'b0, hand} + sel_k;
    if (idx >= (WAY_W+1)'(WAYS)) idx = idx - (WAY_W+1)'(WAYS);
    vic_way = inv_f ? inv_way : idx[WAY_W-1:0];
    hand_n  = hand;
    if (!inv_f) begin
      for (int k = 0; k < WAYS; k++) begin
        if (!free_f || ((WAY_W+1)'(k) < sel_k)) begin
          idx = {1'b0, hand} + (WAY_W+1)'(k);
          if (idx >= (WAY_W+1)'(WAYS)) idx = idx - (WAY_W+1)'(WAYS);
          used_n[idx[WAY_W-1:0]] = 1'b0;
        end
      end
      hand_n = (vic_way == WAY_W'(WAYS - 1)) ? '0 : vic_way + WAY_W'(1);
    end
  end

  // Build the updated row
  always_comb begin
    row_n   = rdata;
    valid_n = valid;
    dirty_n = dirty;
    evd_e   = valid[vic_way] && dirty[vic_way];
    evl_e   = {tags[vic_way], set_e};
    if (hit_e) begin
      if (dirty_e) dirty_n[hit_way] = 1'b1;
      row_n[TB + 2*WAYS +: WAYS] = used;
      row_n[TB + 2*WAYS + int'(hit_way)] = 1'b1;
      row_n[TB + WAYS +: WAYS] = dirty_n;
    end else begin
      valid_n[vic_way] = 1'b1;
      dirty_n[vic_way] = dirty_e;
      row_n[int'(vic_way)*TAG_W +: TAG_W] = tag_e;
      row_n[TB +: WAYS]           = valid_n;
      row_n[TB + WAYS +: WAYS]    = dirty_n;
      row_n[TB + 2*WAYS +: WAYS]  = used_n & ~(WAYS'(1) << vic_way);
      row_n[TB + 3*WAYS +: WAY_W] = hand_n;
    end
  end

  assign sts.hit = hit_e;

  // Route the RAM ports
  assign we    = cmd.clear || cmd.look || (cmd.pref && !hit_e);
  assign waddr = cmd.clear ? clr_cnt : set_e;
  assign wdata = cmd.clear ? '0 : row_n;
  assign raddr = cmd.look ? pline[SET_W-1:0] : address[OFF_W +: SET_W];

  dcclp_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Strobe the result
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.look && hit_e) || cmd.pref;
    end
  end

  // Hold result fields
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      hit                  <= hit_e;
      demand_way           <= hit_e ? hit_way : vic_way;
      evict_dirty          <= !hit_e && evd_e;
      evict_line           <= (!hit_e && evd_e) ? evl_e : '0;
      fill_line            <= hit_e ? '0 : line_q;
      prefetch_fill        <= 1'b0;
      prefetch_line        <= '0;
      prefetch_way         <= '0;
      prefetch_evict_dirty <= 1'b0;
      prefetch_evict_line  <= '0;
    end else if (cmd.pref) begin
      prefetch_fill        <= !hit_e;
      prefetch_line        <= hit_e ? '0 : pline;
      prefetch_way         <= hit_e ? '0 : vic_way;
      prefetch_evict_dirty <= !hit_e && evd_e;
      prefetch_evict_line  <= (!hit_e && evd_e) ? evl_e : '0;
    end
  end
endmodule
`default_nettype wire

FILE: sim/tb_data_cache_clock_lip_prefetch.sv
// Testbench of the data cache directory: directed table, then random accesses checked by a model.
`default_nettype none
module tb_data_cache_clock_lip_prefetch;
  import dcclp_pkg::*;

  localparam int SETS = 128;
  localparam int WAYS = 8;
  localparam int LINE_BYTES = 64;
  localparam int AW = 48;
  localparam int LW = 42;
  localparam int N_RAND = 1300;

  typedef struct packed {
    logic          hit;
    logic [2:0]    demand_way;
    logic          evict_dirty;
    logic [LW-1:0] evict_line;
    logic [LW-1:0] fill_line;
    logic          prefetch_fill;
    logic [LW-1:0] prefetch_line;
    logic [2:0]    prefetch_way;
    logic          prefetch_evict_dirty;
    logic [LW-1:0] prefetch_evict_line;
  } outcome_t;

  typedef struct {
    logic [1:0]    md;
    logic [AW-1:0] addr;
    logic          known;
    outcome_t      res;
  } row_t;

  logic clk = 0, rst = 1, start = 0;
  logic [1:0] mode = MODE_LOAD;
  logic [AW-1:0] address = '0;
  logic busy, done, hit, evict_dirty, prefetch_fill, prefetch_evict_dirty;
  logic [2:0] demand_way, prefetch_way;
  logic [LW-1:0] evict_line, fill_line, prefetch_line, prefetch_evict_line;

  data_cache_clock_lip_prefetch i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode), .address(address),
    .done(done), .hit(hit), .demand_way(demand_way), .evict_dirty(evict_dirty),
    .evict_line(evict_line), .fill_line(fill_line), .prefetch_fill(prefetch_fill),
    .prefetch_line(prefetch_line), .prefetch_way(prefetch_way),
    .prefetch_evict_dirty(prefetch_evict_dirty),
    .prefetch_evict_line(prefetch_evict_line)
  );

  always #4 clk = ~clk;

  // Shadow directory
  logic          dir_valid [SETS][WAYS];
  logic          dir_dirty [SETS][WAYS];
  logic          dir_used  [SETS][WAYS];
  logic [34:0]   dir_tag   [SETS][WAYS];
  logic [2:0]    hand      [SETS];

  outcome_t pending_results[$];
  int errors = 0, n_hits = 0, n_pref = 0, n_wb = 0, n_seen = 0;
  int idle_pct = 0;

  function automatic int find_way(logic [LW-1:0] ln);
    int s;
    s = int'(ln % SETS);
    for (int w = 0; w < WAYS; w++)
      if (dir_valid[s][w] && dir_tag[s][w] == ln[LW-1:7]) return w;
    return WAYS;
  endfunction

  function automatic int choose_victim(int s);
    int cur;
    for (int w = 0; w < WAYS; w++)
      if (!dir_valid[s][w]) return w;
    for (int n = 0; n <= WAYS; n++) begin
      cur = int'(hand[s]);
      hand[s] = hand[s] + 3'd1;
      if (!dir_used[s][cur]) return cur;
      dir_used[s][cur] = 0;
    end
    return 0;
  endfunction

  task automatic fill_into(input logic [LW-1:0] ln, input logic drt, output logic [2:0] way,
                           output logic evd, output logic [LW-1:0] evl);
    int s, w;
    s = int'(ln % SETS);
    w = choose_victim(s);
    evd = 0;
    evl = '0;
    if (dir_valid[s][w] && dir_dirty[s][w]) begin
      evd = 1;
      evl = {dir_tag[s][w], 7'(s)};
    end
    dir_valid[s][w] = 1;
    dir_dirty[s][w] = drt;
    dir_used[s][w] = 0;
    dir_tag[s][w] = ln[LW-1:7];
    way = 3'(w);
  endtask

  task automatic predict_access(input logic [1:0] md, input logic [AW-1:0] addr,
                                output outcome_t r);
    logic writes;
    logic [LW-1:0] ln, pln;
    logic [AW-1:0] pa;
    int w, s;
    writes = (md == MODE_STORE || md == MODE_MODIFY);
    ln = addr[AW-1:6];
    s = int'(ln % SETS);
    w = find_way(ln);
    r = '0;
    if (w < WAYS) begin
      dir_used[s][w] = 1;
      if (writes) dir_dirty[s][w] = 1;
      r.hit = 1;
      r.demand_way = 3'(w);
    end else begin
      fill_into(ln, writes, r.demand_way, r.evict_dirty, r.evict_line);
      r.fill_line = ln;
      pa = addr + AW'(LINE_BYTES);
      pln = pa[AW-1:6];
      if (find_way(pln) >= WAYS) begin
        r.prefetch_fill = 1;
        r.prefetch_line = pln;
        fill_into(pln, 1'b0, r.prefetch_way, r.prefetch_evict_dirty, r.prefetch_evict_line);
      end
    end
  endtask

  // Compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    outcome_t exp_r;
    if (!rst && done) begin
      n_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.hit) n_hits++;
        if (exp_r.prefetch_fill) n_pref++;
        if (exp_r.evict_dirty || exp_r.prefetch_evict_dirty) n_wb++;
        if (hit !== exp_r.hit) begin
          $error("hit exp %0h got %0h", exp_r.hit, hit); errors++; end
        if (demand_way !== exp_r.demand_way) begin
          $error("demand_way exp %0h got %0h", exp_r.demand_way, demand_way); errors++; end
        if (evict_dirty !== exp_r.evict_dirty) begin
          $error("evict_dirty exp %0h got %0h", exp_r.evict_dirty, evict_dirty); errors++; end
        if (evict_line !== exp_r.evict_line) begin
          $error("evict_line exp %0h got %0h", exp_r.evict_line, evict_line); errors++; end
        if (fill_line !== exp_r.fill_line) begin
          $error("fill_line exp %0h got %0h", exp_r.fill_line, fill_line); errors++; end
        if (prefetch_fill !== exp_r.prefetch_fill) begin
          $error("prefetch_fill exp %0h got %0h", exp_r.prefetch_fill, prefetch_fill);
          errors++; end
        if (prefetch_line !== exp_r.prefetch_line) begin
          $error("prefetch_line exp %0h got %0h", exp_r.prefetch_line, prefetch_line);
          errors++; end
        if (prefetch_way !== exp_r.prefetch_way) begin
          $error("prefetch_way exp %0h got %0h", exp_r.prefetch_way, prefetch_way); errors++; end
        if (prefetch_evict_dirty !== exp_r.prefetch_evict_dirty) begin
          $error("prefetch_evict_dirty exp %0h got %0h", exp_r.prefetch_evict_dirty,
                 prefetch_evict_dirty); errors++; end
        if (prefetch_evict_line !== exp_r.prefetch_evict_line) begin
          $error("prefetch_evict_line exp %0h got %0h", exp_r.prefetch_evict_line,
                 prefetch_evict_line); errors++; end
      end
    end
  end

  // Present one item and hold it until taken
  task automatic send_access(input logic [1:0] md, input logic [AW-1:0] addr,
                             input logic known, input outcome_t typed);
    outcome_t r;
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    mode <= md;
    address <= addr;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_access(md, addr, r);
    if (known && r !== typed) begin
      $error("directed row mismatch: exp %0h model %0h", typed, r);
      errors++;
    end
    pending_results.push_back(r);
  endtask

  // Random address drawn from a few hot regions so sets fill and sweep
  function automatic logic [AW-1:0] pick_address();
    logic [AW-1:0] a;
    int k;
    a = AW'({$urandom, $urandom});
    k = $urandom_range(9);
    if (k < 6) a[AW-1:13] = 35'($urandom_range(11));
    else if (k == 6) a[AW-1:13] = '1;
    else if (k == 7) a[AW-1:13] = 35'($urandom_range(40));
    if (k < 8 && $urandom_range(1)) a[12:6] = 7'($urandom_range(3));
    return a;
  endfunction

  row_t dir_rows[$];
  outcome_t z;

  initial begin
    for (int s = 0; s < SETS; s++) begin
      hand[s] = 0;
      for (int w = 0; w < WAYS; w++) begin
        dir_valid[s][w] = 0; dir_dirty[s][w] = 0; dir_used[s][w] = 0; dir_tag[s][w] = '0;
      end
    end
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // First access: cold miss at address zero, next line also prefetched
    z = '0; z.fill_line = 0; z.prefetch_fill = 1; z.prefetch_line = 1;
    z.prefetch_way = 0;
    dir_rows.push_back('{MODE_LOAD, '0, 1'b1, z});
    z = '0; z.hit = 1;
    dir_rows.push_back('{MODE_STORE, AW'(63), 1'b1, z});
    z = '0; z.hit = 1;
    dir_rows.push_back('{MODE_MODIFY, AW'(64), 1'b1, z});
    // Top address: prefetch wraps to line zero, which is present
    z = '0; z.demand_way = 0; z.fill_line = '1;
    dir_rows.push_back('{2'd3, '1, 1'b1, z});
    // Unused mode leaves lines clean; fill one set past its ways
    for (int i = 0; i < 12; i++)
      dir_rows.push_back('{2'(i % 4), AW'(i) << 13, 1'b0, '0});
    for (int i = 0; i < 6; i++)
      dir_rows.push_back('{2'(i % 3), (AW'(i) << 13) | AW'(i * 5), 1'b0, '0});
    dir_rows.push_back('{MODE_STORE, {35'h5a5a5a5a5, 13'h1fc0}, 1'b0, '0});
    foreach (dir_rows[i])
      send_access(dir_rows[i].md, dir_rows[i].addr, dir_rows[i].known, dir_rows[i].res);

    for (int i = 0; i < N_RAND; i++) begin
      case ((i * 4) / N_RAND)
        0: idle_pct = 0;
        1: idle_pct = 84;
        2: idle_pct = 33;
        default: idle_pct = (i % 200 < 100) ? 0 : 84;
      endcase
      send_access(2'($urandom_range(3)), pick_address(), 1'b0, '0);
    end
    start <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Ran %0d accesses: %0d hits, %0d prefetches, %0d write-backs.",
             n_seen, n_hits, n_pref, n_wb);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
rtl/core/dcclp_pkg.sv
rtl/core/dcclp_ram.sv
rtl/core/dcclp_ctrl.sv
rtl/core/dcclp_dp.sv
rtl/core/data_cache_clock_lip_prefetch.sv
sim/tb_data_cache_clock_lip_prefetch.sv
